FILE: rtl/spi_master_fifo_timing_defines.svh
// Assertion macros shared by the SPI master RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef SPI_MASTER_FIFO_TIMING_DEFINES_SVH
`define SPI_MASTER_FIFO_TIMING_DEFINES_SVH

// Checked on every rising edge outside reset.
`define SMFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SMFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/smft_pkg.sv
// Shared types, codes and byte-time table for the SPI master.
// No dependencies.
package smft_pkg;

  localparam int unsigned CmdW        = 2;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 4;
  localparam int unsigned TimerW      = 10;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 24;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CLK_SEL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_IRQ_MSK = 2'd2;

  localparam int unsigned ST_RX_FULL  = 0;
  localparam int unsigned ST_RX_READY = 1;
  localparam int unsigned ST_TX_EMPTY = 2;
  localparam int unsigned ST_TX_READY = 3;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e        kind;
    logic [7:0] tx_byte;
    logic [7:0] reply;
  } op_t;

  function automatic logic [TimerW-1:0] byte_ticks(input logic [2:0] sel);
    logic [TimerW-1:0] t;
    case (sel)
      3'd0:    t = 10'd16;
      3'd1:    t = 10'd32;
      3'd2:    t = 10'd64;
      3'd3:    t = 10'd128;
      3'd4:    t = 10'd256;
      default: t = 10'd512;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/smft_front.sv
// Input stage: takes stream items, classifies the command, hands ops to the queue.
// Depends on smft_pkg.
module smft_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  output logic                      s_ready_o,
  input  logic [smft_pkg::InDataW-1:0] s_data_i,
  input  logic [smft_pkg::CmdW-1:0] s_user_i,
  output logic                      push_o,
  input  logic                      push_ready_i,
  output smft_pkg::op_t             op_o
);

  logic          v_q, v_d;
  smft_pkg::op_t op_q, op_d;
  logic          accept;

  assign s_ready_o = !v_q || push_ready_i;
  assign accept    = s_valid_i && s_ready_o;
  assign push_o    = v_q;
  assign op_o      = op_q;

  always_comb begin
    op_d         = op_q;
    op_d.tx_byte = s_data_i[7:0];
    op_d.reply   = s_data_i[15:8];
    case (s_user_i)
      smft_pkg::CMD_TICK:  op_d.kind = smft_pkg::OP_TICK;
      smft_pkg::CMD_WRITE: op_d.kind = smft_pkg::OP_WRITE;
      smft_pkg::CMD_READ:  op_d.kind = smft_pkg::OP_READ;
      default:             op_d.kind = smft_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    v_d = v_q;
    if (accept) begin
      v_d = 1'b1;
    end else if (push_ready_i) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

endmodule

FILE: rtl/smft_queue.sv
// Short op queue between the front and back parts.
// Depends on smft_pkg.
module smft_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          push_ready_o,
  input  smft_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output smft_pkg::op_t pop_op_o
);

  localparam int unsigned QPW = (smft_pkg::QueueDepth > 1) ?
                                $clog2(smft_pkg::QueueDepth) : 1;
  localparam int unsigned QCW = $clog2(smft_pkg::QueueDepth + 1);

  smft_pkg::op_t  mem_q [smft_pkg::QueueDepth];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign push_ready_o = cnt_q != QCW'(smft_pkg::QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_op_o     = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPW'(smft_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPW'(smft_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: rtl/smft_back.sv
// Execution part: FIFOs, shifter, byte timer, status, config and result register.
// Depends on smft_pkg and spi_master_fifo_timing_defines.svh.
`include "spi_master_fifo_timing_defines.svh"

module smft_back #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smft_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [smft_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            op_valid_i,
  output logic                            op_pop_o,
  input  smft_pkg::op_t                   op_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [smft_pkg::OutDataW-1:0]   m_data_o
);

  localparam int unsigned LW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned IW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [LW-1:0] DepthL = LW'(FIFO_DEPTH);

  logic [7:0] tx_store_q [FIFO_DEPTH];
  logic [7:0] tx_store_d [FIFO_DEPTH];
  logic [7:0] rx_store_q [FIFO_DEPTH];
  logic [7:0] rx_store_d [FIFO_DEPTH];
  logic [LW-1:0] tx_level_q, tx_level_d, rx_level_q, rx_level_d;
  logic [smft_pkg::TimerW-1:0] byte_timer_q, byte_timer_d, timer_after;
  logic [7:0] shift_byte_q, shift_byte_d;
  logic [3:0] status_q, status_d;
  logic       irq_q, irq_d, stale_q, stale_d;
  logic       en_q;
  logic [2:0] clk_sel_q;
  logic [3:0] irq_mask_q;
  logic       fire;
  logic       out_valid_q, out_valid_d;
  logic [smft_pkg::OutDataW-1:0] out_data_q;
  logic [7:0] rd_byte, sent_byte;
  logic       err, done;

  assign fire      = op_valid_i && (!out_valid_q || m_ready_i);
  assign op_pop_o  = fire;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  always_comb begin
    tx_store_d   = tx_store_q;
    rx_store_d   = rx_store_q;
    tx_level_d   = tx_level_q;
    rx_level_d   = rx_level_q;
    byte_timer_d = byte_timer_q;
    shift_byte_d = shift_byte_q;
    status_d     = status_q;
    irq_d        = irq_q;
    stale_d      = stale_q;
    timer_after  = byte_timer_q;
    rd_byte      = '0;
    sent_byte    = '0;
    err          = 1'b0;
    done         = 1'b0;
    if (fire) begin
      case (op_i.kind)
        smft_pkg::OP_WRITE: begin
          if (tx_level_q < DepthL) begin
            tx_store_d[tx_level_q[IW-1:0]] = op_i.tx_byte;
            tx_level_d = tx_level_q + 1'b1;
            stale_d    = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        smft_pkg::OP_READ: begin
          rd_byte = rx_store_q[0];
          if (rx_level_q != '0) begin
            for (int i = 0; i < int'(FIFO_DEPTH) - 1; i++) begin
              rx_store_d[i] = rx_store_q[i+1];
            end
            rx_level_d = rx_level_q - 1'b1;
            stale_d    = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        smft_pkg::OP_TICK: begin
          if (en_q) begin
            if (byte_timer_q != '0) begin
              timer_after = byte_timer_q - 1'b1;
              if (timer_after == '0) begin
                done      = 1'b1;
                sent_byte = shift_byte_q;
                if (rx_level_q < DepthL) begin
                  rx_store_d[rx_level_q[IW-1:0]] = op_i.reply;
                  rx_level_d = rx_level_q + 1'b1;
                end else begin
                  err = 1'b1;
                end
              end
              stale_d = 1'b1;
            end
            byte_timer_d = timer_after;
            if (tx_level_q != '0 && timer_after == '0) begin
              shift_byte_d = tx_store_q[0];
              for (int i = 0; i < int'(FIFO_DEPTH) - 1; i++) begin
                tx_store_d[i] = tx_store_q[i+1];
              end
              tx_level_d   = tx_level_q - 1'b1;
              byte_timer_d = smft_pkg::byte_ticks(clk_sel_q);
              stale_d      = 1'b1;
            end
            if (stale_d) begin
              status_d[smft_pkg::ST_RX_FULL]  = rx_level_d == DepthL;
              status_d[smft_pkg::ST_RX_READY] = rx_level_d != '0;
              status_d[smft_pkg::ST_TX_EMPTY] = tx_level_d == '0;
              status_d[smft_pkg::ST_TX_READY] = tx_level_d != DepthL;
              irq_d   = |(status_d & ~irq_mask_q);
              stale_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_store_q   <= '{default: '0};
      tx_level_q   <= '0;
      rx_level_q   <= '0;
      byte_timer_q <= '0;
      shift_byte_q <= '0;
      status_q     <= '0;
      irq_q        <= 1'b0;
      stale_q      <= 1'b1;
      en_q         <= 1'b0;
      clk_sel_q    <= '0;
      irq_mask_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      rx_store_q   <= rx_store_d;
      tx_level_q   <= tx_level_d;
      rx_level_q   <= rx_level_d;
      byte_timer_q <= byte_timer_d;
      shift_byte_q <= shift_byte_d;
      status_q     <= status_d;
      irq_q        <= irq_d;
      stale_q      <= stale_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          smft_pkg::REG_ENABLE:  en_q       <= cfg_data_i[0];
          smft_pkg::REG_CLK_SEL: clk_sel_q  <= cfg_data_i[2:0];
          smft_pkg::REG_IRQ_MSK: irq_mask_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tx_store_q <= tx_store_d;
    if (fire) begin
      out_data_q <= {1'b0, sent_byte, done, err, irq_d & en_q, status_d, rd_byte};
    end
  end

  `SMFT_ASSERT(a_level_bound, (tx_level_q <= DepthL) && (rx_level_q <= DepthL), "level out of range")
  `SMFT_ASSERT(a_done_timer, (fire && done) |-> (byte_timer_q == 10'd1), "done without timer expiry")
  `SMFT_ASSERT(a_idle_hold, !fire |=> ($stable(tx_level_q) && $stable(rx_level_q)), "level moved idle")
  `SMFT_ASSERT(a_timer_bound, byte_timer_q <= 10'd512, "byte timer out of range")
  `SMFT_ASSERT_ALWAYS(a_reset_clear, !rst_ni |=> !out_valid_q, "result valid during reset")

endmodule

FILE: rtl/spi_master_fifo_timing.sv
// Top level of the SPI master with transmit and receive FIFOs.
// Depends on smft_pkg, smft_front, smft_queue, smft_back.
//
// channel  | direction | handshake         | payload
// s_axis   | in        | tvalid/tready     | tdata: tx_byte, partner_reply; tuser: cmd
// m_axis   | out       | tvalid/tready     | tdata: read_byte, status_bits, irq, xrun_error,
//          |           |                   |        byte_done, sent_byte
// cfg      | in        | cfg_we_i          | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while the output accepts; each result passes the input register,
// the op queue, then the result register. The back part executes one op per cycle unless stalled.
// Asynchronous active-low reset; no clearing pass, the block takes items right after reset.
// A stalled output holds the result register; the two-entry queue and input register
// absorb the stall before s_axis_tready drops.
module spi_master_fifo_timing #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smft_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [smft_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] tx_byte, [15:8] partner_reply
  input  logic [smft_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [smft_pkg::CmdW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] read_byte, [11:8] status_bits, [12] irq, [13] xrun_error,
  // [14] byte_done, [22:15] sent_byte, [23] zero
  output logic [smft_pkg::OutDataW-1:0] m_axis_tdata
);

  logic          push, push_ready, pop_valid, pop;
  smft_pkg::op_t push_op, pop_op;

  smft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .push_o       (push),
    .push_ready_i (push_ready),
    .op_o         (push_op)
  );

  smft_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_op_o     (pop_op)
  );

  smft_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .op_valid_i (pop_valid),
    .op_pop_o   (pop),
    .op_i       (pop_op),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata)
  );

endmodule
